### sv/abp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abp_pkg;

  // Default number of messages the queue holds.
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Retransmit timeout after reset, in ticks.
  localparam logic [15:0] TIMEOUT_RESET = 16'd15;

  // Payload geometry.
  localparam int unsigned PAYLOAD_BYTES = 20;
  localparam int unsigned PAYLOAD_W     = 8 * PAYLOAD_BYTES;

  // Width of a sum of 20 sign-extended bytes.
  localparam int unsigned PSUM_W = 13;

  // Event codes of an input word.
  typedef enum logic [1:0] {
    CMD_MSG  = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // One queue entry: the payload and its byte sum, kept so that the
  // checksum of a dequeued message needs no second adder tree.
  typedef struct packed {
    logic [63:0]              lo;
    logic [63:0]              mid;
    logic [31:0]              hi;
    logic signed [PSUM_W-1:0] psum;
  } entry_t;

  // Queue controls from the decision stage.
  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

  // Sum of the 20 payload bytes, each sign-extended. The terms are added
  // pairwise, so the adder depth is five levels.
  function automatic logic signed [PSUM_W-1:0] payload_sum(
    input logic [63:0] lo,
    input logic [63:0] mid,
    input logic [31:0] hi
  );
    logic [PAYLOAD_W-1:0]        bytes;
    logic [31:0][PSUM_W-1:0]     part;
    logic [7:0]                  b;
    bytes = {hi, mid, lo};
    part  = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      b       = bytes[8*i +: 8];
      part[i] = {{(PSUM_W-8){b[7]}}, b};
    end
    for (int w = 16; w > 0; w = w >> 1) begin
      for (int i = 0; i < w; i++) begin
        part[i] = part[2*i] + part[2*i+1];
      end
    end
    return part[0];
  endfunction

  // Packet checksum: seq + ack + byte sum, 32-bit wrap.
  function automatic logic [31:0] pkt_checksum(
    input logic                     seq,
    input logic                     ack,
    input logic signed [PSUM_W-1:0] psum
  );
    return {{(32-PSUM_W){psum[PSUM_W-1]}}, psum} + {31'd0, seq} + {31'd0, ack};
  endfunction

endpackage

`default_nettype wire

### sv/abp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Event channel into the sender.
interface abp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic               seq_in;
  logic               ack_in;
  logic signed [31:0] checksum_in;
  logic [63:0]        payload_lo;
  logic [63:0]        payload_mid;
  logic [31:0]        payload_hi;

  modport source (
    output valid, cmd, seq_in, ack_in, checksum_in, payload_lo, payload_mid, payload_hi,
    input  ready
  );
  modport sink (
    input  valid, cmd, seq_in, ack_in, checksum_in, payload_lo, payload_mid, payload_hi,
    output ready
  );
endinterface

// Result channel out of the sender.
interface abp_out_if;
  logic               valid;
  logic               ready;
  logic               sent;
  logic               seq_out;
  logic               ack_out;
  logic signed [31:0] checksum_out;
  logic [63:0]        out_lo;
  logic [63:0]        out_mid;
  logic [31:0]        out_hi;
  logic               dropped;
  logic [4:0]         queue_level;

  modport source (
    output valid, sent, seq_out, ack_out, checksum_out, out_lo, out_mid, out_hi,
           dropped, queue_level,
    input  ready
  );
  modport sink (
    input  valid, sent, seq_out, ack_out, checksum_out, out_lo, out_mid, out_hi,
           dropped, queue_level,
    output ready
  );
endinterface

`default_nettype wire

### sv/abp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Circular message queue. The head entry is read into a register every
// cycle at the next head address, so head_o always shows the current head.
module abp_queue #(
  parameter int unsigned DEPTH = abp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  abp_pkg::qctl_t              ctl_i,
  input  abp_pkg::entry_t             wdata_i,
  output abp_pkg::entry_t             head_o,
  output logic [$clog2(DEPTH+1)-1:0]  count_o,
  output logic [$clog2(DEPTH+1)-1:0]  count_next_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  abp_pkg::entry_t mem [DEPTH];
  abp_pkg::entry_t rd_q;

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointer and count updates.
  always_comb begin
    head_d  = ctl_i.pop ? ptr_inc(head_q) : head_q;
    tail_d  = ctl_i.push ? ptr_inc(tail_q) : tail_q;
    count_d = count_q + CNT_W'(ctl_i.push) - CNT_W'(ctl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Storage write at the tail.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= wdata_i;
    end
  end

  // Registered head read, with the word being written passed through.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push && (tail_q == head_d)) begin
      rd_q <= wdata_i;
    end else begin
      rd_q <= mem[head_d];
    end
  end

  assign head_o       = rd_q;
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

`default_nettype wire

### sv/abp_sender_with_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Alternating-bit protocol sender with a message queue. Each input word is
// an event (message, ack packet or timer tick) and yields exactly one
// result word telling whether a data packet went out, its fields, whether
// a message was dropped on a full queue, and the queue level. An event
// passes through an input register and one decision stage into the result
// register, so the block takes one word per cycle unless the output stalls;
// the queue head is kept in a register refreshed every cycle, so the
// decision stage dequeues straight from it. The timeout register should be
// written only while no word is in flight.
module abp_sender_with_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = abp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [15:0] cfg_wdata_i,
  abp_in_if.sink      in_i,
  abp_out_if.source   out_o
);

  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PSUM_W = abp_pkg::PSUM_W;

  // Timeout register.
  logic [15:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= abp_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Input register.
  logic               s1_vld_q;
  abp_pkg::cmd_e      s1_cmd_q;
  logic               s1_seq_q;
  logic               s1_ack_q;
  logic [31:0]        s1_chk_q;
  logic [63:0]        s1_lo_q;
  logic [63:0]        s1_mid_q;
  logic [31:0]        s1_hi_q;
  logic               out_vld_q;
  logic               fire;

  assign fire       = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_cmd_q <= abp_pkg::cmd_e'(in_i.cmd);
      s1_seq_q <= in_i.seq_in;
      s1_ack_q <= in_i.ack_in;
      s1_chk_q <= in_i.checksum_in;
      s1_lo_q  <= in_i.payload_lo;
      s1_mid_q <= in_i.payload_mid;
      s1_hi_q  <= in_i.payload_hi;
    end
  end

  // Protocol state.
  logic        wait_q, wait_d;
  logic        exp_ack_q, exp_ack_d;
  logic        seq_q, seq_d;
  logic [63:0] cur_lo_q, cur_lo_d;
  logic [63:0] cur_mid_q, cur_mid_d;
  logic [31:0] cur_hi_q, cur_hi_d;
  logic [31:0] cur_chk_q, cur_chk_d;
  logic [15:0] timer_q, timer_d;

  // Queue.
  abp_pkg::qctl_t  qctl;
  abp_pkg::entry_t q_wdata;
  abp_pkg::entry_t q_head;
  logic [CNT_W-1:0] q_count;
  logic [CNT_W-1:0] q_count_next;

  abp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (qctl),
    .wdata_i      (q_wdata),
    .head_o       (q_head),
    .count_o      (q_count),
    .count_next_o (q_count_next)
  );

  // Decision stage.
  logic signed [PSUM_W-1:0] in_psum;
  logic [31:0]              ack_chk;
  logic [15:0]              timer_start;
  logic                     snd;
  logic                     src_head;
  logic                     src_cur;
  logic                     drop;
  logic [63:0]              snd_lo;
  logic [63:0]              snd_mid;
  logic [31:0]              snd_hi;
  logic [31:0]              snd_chk;

  assign in_psum     = abp_pkg::payload_sum(s1_lo_q, s1_mid_q, s1_hi_q);
  assign ack_chk     = abp_pkg::pkt_checksum(s1_seq_q, s1_ack_q, in_psum);
  assign timer_start = (timeout_q == '0) ? 16'd1 : timeout_q;
  assign q_wdata     = '{lo: s1_lo_q, mid: s1_mid_q, hi: s1_hi_q, psum: in_psum};

  always_comb begin
    wait_d    = wait_q;
    exp_ack_d = exp_ack_q;
    seq_d     = seq_q;
    timer_d   = timer_q;
    qctl      = '0;
    snd       = 1'b0;
    src_head  = 1'b0;
    src_cur   = 1'b0;
    drop      = 1'b0;

    if (fire) begin
      unique case (s1_cmd_q)
        abp_pkg::CMD_MSG: begin
          if (!wait_q) begin
            snd       = 1'b1;
            if (q_count != '0) begin
              // Older messages go first; the new one joins the tail.
              src_head  = 1'b1;
              qctl.pop  = 1'b1;
              qctl.push = 1'b1;
            end
          end else if (q_count < CNT_W'(QUEUE_DEPTH)) begin
            qctl.push = 1'b1;
          end else begin
            drop = 1'b1;
          end
        end
        abp_pkg::CMD_ACK: begin
          if (wait_q && (s1_ack_q == exp_ack_q) && (ack_chk == s1_chk_q)) begin
            wait_d    = 1'b0;
            timer_d   = '0;
            exp_ack_d = ~exp_ack_q;
            seq_d     = ~seq_q;
            if (q_count != '0) begin
              snd      = 1'b1;
              src_head = 1'b1;
              qctl.pop = 1'b1;
            end
          end
        end
        abp_pkg::CMD_TICK: begin
          if (timer_q != '0) begin
            timer_d = timer_q - 16'd1;
            if (timer_q == 16'd1) begin
              snd     = 1'b1;
              src_cur = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // Packet selection.
    if (src_cur) begin
      snd_lo  = cur_lo_q;
      snd_mid = cur_mid_q;
      snd_hi  = cur_hi_q;
      snd_chk = cur_chk_q;
    end else if (src_head) begin
      snd_lo  = q_head.lo;
      snd_mid = q_head.mid;
      snd_hi  = q_head.hi;
      snd_chk = abp_pkg::pkt_checksum(seq_d, 1'b0, q_head.psum);
    end else begin
      snd_lo  = s1_lo_q;
      snd_mid = s1_mid_q;
      snd_hi  = s1_hi_q;
      snd_chk = abp_pkg::pkt_checksum(seq_d, 1'b0, in_psum);
    end

    cur_lo_d  = cur_lo_q;
    cur_mid_d = cur_mid_q;
    cur_hi_d  = cur_hi_q;
    cur_chk_d = cur_chk_q;
    if (snd) begin
      cur_lo_d  = snd_lo;
      cur_mid_d = snd_mid;
      cur_hi_d  = snd_hi;
      cur_chk_d = snd_chk;
      wait_d    = 1'b1;
      timer_d   = timer_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q    <= 1'b0;
      exp_ack_q <= 1'b0;
      seq_q     <= 1'b0;
      cur_lo_q  <= '0;
      cur_mid_q <= '0;
      cur_hi_q  <= '0;
      cur_chk_q <= '0;
      timer_q   <= '0;
    end else begin
      wait_q    <= wait_d;
      exp_ack_q <= exp_ack_d;
      seq_q     <= seq_d;
      cur_lo_q  <= cur_lo_d;
      cur_mid_q <= cur_mid_d;
      cur_hi_q  <= cur_hi_d;
      cur_chk_q <= cur_chk_d;
      timer_q   <= timer_d;
    end
  end

  // Result register.
  logic        r_sent_q;
  logic        r_seq_q;
  logic [31:0] r_chk_q;
  logic [63:0] r_lo_q;
  logic [63:0] r_mid_q;
  logic [31:0] r_hi_q;
  logic        r_drop_q;
  logic [4:0]  r_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      r_sent_q  <= snd;
      r_seq_q   <= snd ? seq_d : 1'b0;
      r_chk_q   <= snd ? snd_chk : 32'd0;
      r_lo_q    <= snd ? snd_lo : 64'd0;
      r_mid_q   <= snd ? snd_mid : 64'd0;
      r_hi_q    <= snd ? snd_hi : 32'd0;
      r_drop_q  <= drop;
      r_level_q <= 5'(q_count_next);
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.sent         = r_sent_q;
  assign out_o.seq_out      = r_seq_q;
  assign out_o.ack_out      = 1'b0;
  assign out_o.checksum_out = r_chk_q;
  assign out_o.out_lo       = r_lo_q;
  assign out_o.out_mid      = r_mid_q;
  assign out_o.out_hi       = r_hi_q;
  assign out_o.dropped      = r_drop_q;
  assign out_o.queue_level  = r_level_q;

  // The retransmit timer runs exactly while a packet is unacknowledged.
  a_timer_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q == (timer_q != '0))
    else $error("timer state disagrees with waiting flag");

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // A word that drops a message never also sends a packet.
  a_drop_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(r_drop_q && r_sent_q))
    else $error("drop and send in one result word");

  // A dropped message implies the queue was full and stays full.
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && drop) |=> (q_count == CNT_W'(QUEUE_DEPTH)))
    else $error("message dropped with room in the queue");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int FIFO_SLOTS = abp_pkg::QUEUE_DEPTH_DEF;

  // One event word as the sender sees it.
  typedef struct packed {
    abp_pkg::cmd_e cmd;
    logic          seq_in;
    logic          ack_in;
    logic [31:0]   checksum_in;
    logic [63:0]   lo;
    logic [63:0]   mid;
    logic [31:0]   hi;
  } sender_evt_t;

  // One result word as the sender emits it.
  typedef struct packed {
    logic        sent;
    logic        seq_out;
    logic        ack_out;
    logic [31:0] checksum;
    logic [63:0] lo;
    logic [63:0] mid;
    logic [31:0] hi;
    logic        dropped;
    logic [4:0]  level;
  } packet_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  abp_in_if  in_ch ();
  abp_out_if out_ch ();

  abp_sender_with_queue_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Clock with a 2 ns period.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Shadow copy of the sender state.
  logic [63:0] q_lo  [FIFO_SLOTS];
  logic [63:0] q_mid [FIFO_SLOTS];
  logic [31:0] q_hi  [FIFO_SLOTS];
  logic [3:0]  q_head;
  logic [4:0]  q_count;
  logic        busy;
  logic        want_ack;
  logic        cur_seq;
  logic [63:0] cur_lo;
  logic [63:0] cur_mid;
  logic [31:0] cur_hi;
  logic [15:0] ticks_left;
  logic [15:0] timeout_reg;

  packet_res_t packets_due[$];
  int          mismatch_count;
  bit          steady;
  int          msg_weight;

  // Checksum: seq + ack + the 20 payload bytes, each sign-extended.
  function automatic logic [31:0] pkt_sum(input logic seq, input logic ack,
                                          input logic [63:0] lo, input logic [63:0] mid,
                                          input logic [31:0] hi);
    logic [159:0] bytes;
    logic [31:0]  s;
    logic [7:0]   b;
    int           i;
    bytes = {hi, mid, lo};
    s = {31'd0, seq} + {31'd0, ack};
    for (i = 0; i < abp_pkg::PAYLOAD_BYTES; i++) begin
      b = bytes[8*i +: 8];
      s = s + {{24{b[7]}}, b};
    end
    return s;
  endfunction

  // Puts a packet on the wire and restarts the retransmit timer.
  function automatic packet_res_t launch(input logic [63:0] lo, input logic [63:0] mid,
                                         input logic [31:0] hi);
    packet_res_t r;
    r = '0;
    cur_lo = lo;
    cur_mid = mid;
    cur_hi = hi;
    busy = 1'b1;
    ticks_left = (timeout_reg == 16'd0) ? 16'd1 : timeout_reg;
    r.sent = 1'b1;
    r.seq_out = cur_seq;
    r.checksum = pkt_sum(cur_seq, 1'b0, lo, mid, hi);
    r.lo = lo;
    r.mid = mid;
    r.hi = hi;
    return r;
  endfunction

  function automatic void enqueue(input logic [63:0] lo, input logic [63:0] mid,
                                  input logic [31:0] hi);
    logic [3:0] slot;
    slot = q_head + q_count[3:0];
    q_lo[slot] = lo;
    q_mid[slot] = mid;
    q_hi[slot] = hi;
    q_count = q_count + 5'd1;
  endfunction

  function automatic packet_res_t launch_head();
    logic [3:0] slot;
    slot = q_head;
    q_head = q_head + 4'd1;
    q_count = q_count - 5'd1;
    return launch(q_lo[slot], q_mid[slot], q_hi[slot]);
  endfunction

  // Advances the shadow state by one event and returns the word it causes.
  function automatic packet_res_t step_sender(input sender_evt_t ev);
    packet_res_t r;
    r = '0;
    case (ev.cmd)
      abp_pkg::CMD_MSG: begin
        if (!busy) begin
          // The queue is normally empty when idle; keep order if it is not.
          if (q_count != 0) begin
            r = launch_head();
            enqueue(ev.lo, ev.mid, ev.hi);
          end else begin
            r = launch(ev.lo, ev.mid, ev.hi);
          end
        end else if (q_count < FIFO_SLOTS) begin
          enqueue(ev.lo, ev.mid, ev.hi);
        end else begin
          r.dropped = 1'b1;
        end
      end
      abp_pkg::CMD_ACK: begin
        if (busy && ev.ack_in == want_ack &&
            pkt_sum(ev.seq_in, ev.ack_in, ev.lo, ev.mid, ev.hi) == ev.checksum_in) begin
          busy = 1'b0;
          ticks_left = 16'd0;
          want_ack = ~want_ack;
          cur_seq = ~cur_seq;
          if (q_count != 0) r = launch_head();
        end
      end
      abp_pkg::CMD_TICK: begin
        if (ticks_left != 16'd0) begin
          ticks_left = ticks_left - 16'd1;
          if (ticks_left == 16'd0) r = launch(cur_lo, cur_mid, cur_hi);
        end
      end
      default: ;
    endcase
    r.level = q_count;
    return r;
  endfunction

  // Payload patterns: zeros, ones, all bytes at the negative and positive extremes,
  // otherwise random.
  function automatic logic [159:0] payload_pattern(input int sel);
    case (sel)
      0: return '0;
      1: return '1;
      2: return {abp_pkg::PAYLOAD_BYTES{8'h80}};
      3: return {abp_pkg::PAYLOAD_BYTES{8'h7f}};
      default: return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  // Fully random word; callers override the fields that matter.
  function automatic sender_evt_t rand_evt();
    sender_evt_t ev;
    ev.cmd = abp_pkg::cmd_e'($urandom_range(3));
    ev.seq_in = 1'($urandom_range(1));
    ev.ack_in = 1'($urandom_range(1));
    ev.checksum_in = $urandom;
    {ev.hi, ev.mid, ev.lo} = payload_pattern($urandom_range(15));
    return ev;
  endfunction

  function automatic sender_evt_t make_msg(input int sel);
    sender_evt_t ev;
    ev = rand_evt();
    ev.cmd = abp_pkg::CMD_MSG;
    {ev.hi, ev.mid, ev.lo} = payload_pattern(sel);
    return ev;
  endfunction

  function automatic sender_evt_t make_tick();
    sender_evt_t ev;
    ev = rand_evt();
    ev.cmd = abp_pkg::CMD_TICK;
    return ev;
  endfunction

  // Word with the unused command code.
  function automatic sender_evt_t make_none();
    sender_evt_t ev;
    ev = rand_evt();
    ev.cmd = abp_pkg::CMD_NONE;
    return ev;
  endfunction

  // Ack packet; a bad bit or a bad checksum makes the sender ignore it.
  function automatic sender_evt_t make_ack(input bit good_bit, input bit good_sum);
    sender_evt_t ev;
    logic [31:0] s;
    ev = rand_evt();
    ev.cmd = abp_pkg::CMD_ACK;
    ev.ack_in = good_bit ? want_ack : ~want_ack;
    s = pkt_sum(ev.seq_in, ev.ack_in, ev.lo, ev.mid, ev.hi);
    ev.checksum_in = good_sum ? s : s ^ (32'd1 << $urandom_range(31));
    return ev;
  endfunction

  // Sends one word, starting and ending in the time step of a rising edge.
  // Outside steady stretches each cycle idles with a chance of about 22 in 100.
  task automatic send_word(input sender_evt_t ev);
    while (!steady && ($urandom_range(99) < 22)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= ev.cmd;
    in_ch.seq_in      <= ev.seq_in;
    in_ch.ack_in      <= ev.ack_in;
    in_ch.checksum_in <= ev.checksum_in;
    in_ch.payload_lo  <= ev.lo;
    in_ch.payload_mid <= ev.mid;
    in_ch.payload_hi  <= ev.hi;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    packets_due.push_back(step_sender(ev));
  endtask

  // Holds the input until every outstanding result word has arrived.
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (packets_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes the timeout register; the block must be idle.
  task automatic set_timeout(input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    timeout_reg = value;
  endtask

  // Acks, ticks and unknown commands while nothing is in flight.
  task automatic test_idle_events();
    send_word(make_ack(1'b1, 1'b1));
    send_word(make_tick());
    send_word(make_none());
  endtask

  // Fill the queue to the brim, then one more message is dropped.
  task automatic test_queue_full();
    for (int i = 0; i < FIFO_SLOTS + 2; i++) send_word(make_msg(i % 5));
  endtask

  // With the timeout at zero every tick retransmits.
  task automatic test_timer_expiry();
    send_word(make_tick());
    send_word(make_tick());
  endtask

  // Wrong ack bit and bad checksum are ignored; a good ack sends the queue head.
  task automatic test_ack_checks();
    send_word(make_ack(1'b0, 1'b1));
    send_word(make_ack(1'b1, 1'b0));
    send_word(make_ack(1'b1, 1'b1));
  endtask

  // Mostly well-formed traffic with some broken acks and noise.
  task automatic test_random(input int count, input logic [15:0] timeout_value,
                             input bit no_gaps, input int weight);
    int r;
    set_timeout(timeout_value);
    steady = no_gaps;
    msg_weight = weight;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < msg_weight) send_word(make_msg($urandom_range(15)));
      else if (r < msg_weight + 28) send_word(make_ack(1'b1, 1'b1));
      else if (r < msg_weight + 34) send_word(make_ack($urandom_range(1), 1'b0));
      else if (r < msg_weight + 38) send_word(rand_evt());
      else send_word(make_tick());
    end
    wait_results();
    steady = 1'b0;
  endtask

  // Reports one differing field; only the first mismatches are printed.
  function automatic bit field_ok(input string name, input logic [63:0] want_v,
                                  input logic [63:0] got_v);
    if (want_v === got_v) return 1'b1;
    if (mismatch_count < 10)
      $display("%0t: field %s expected %h got %h", $time, name, want_v, got_v);
    return 1'b0;
  endfunction

  // Result checker and random output stalls.
  always @(posedge clk_i) begin
    packet_res_t want;
    bit          ok;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (packets_due.size() == 0) begin
        if (mismatch_count < 10) $display("%0t: result word with none expected", $time);
        mismatch_count++;
      end else begin
        want = packets_due.pop_front();
        ok = field_ok("sent", want.sent, out_ch.sent)
           & field_ok("seq_out", want.seq_out, out_ch.seq_out)
           & field_ok("ack_out", want.ack_out, out_ch.ack_out)
           & field_ok("checksum_out", {32'd0, want.checksum},
                      {32'd0, out_ch.checksum_out})
           & field_ok("out_lo", want.lo, out_ch.out_lo)
           & field_ok("out_mid", want.mid, out_ch.out_mid)
           & field_ok("out_hi", want.hi, out_ch.out_hi)
           & field_ok("dropped", want.dropped, out_ch.dropped)
           & field_ok("queue_level", want.level, out_ch.queue_level);
        if (!ok) mismatch_count++;
      end
    end
    out_ch.ready <= steady || ($urandom_range(99) >= 22);
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("abp_sender_with_queue_unit: mismatch");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = abp_pkg::CMD_NONE;
    in_ch.seq_in = 1'b0;
    in_ch.ack_in = 1'b0;
    in_ch.checksum_in = '0;
    in_ch.payload_lo = '0;
    in_ch.payload_mid = '0;
    in_ch.payload_hi = '0;
    out_ch.ready = 1'b0;
    mismatch_count = 0;
    steady = 1'b0;
    msg_weight = 35;
    q_head = '0;
    q_count = '0;
    busy = 1'b0;
    want_ack = 1'b0;
    cur_seq = 1'b0;
    cur_lo = '0;
    cur_mid = '0;
    cur_hi = '0;
    ticks_left = '0;
    timeout_reg = abp_pkg::TIMEOUT_RESET;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_timeout(16'd0);
    test_idle_events();
    test_queue_full();
    test_timer_expiry();
    test_ack_checks();
    wait_results();

    test_random(260, 16'd1, 1'b0, 35);
    test_random(260, 16'hffff, 1'b1, 35);
    test_random(260, 16'd3, 1'b0, 55);
    test_random(260, 16'($urandom_range(2, 8)), 1'b0, 40);
    test_random(260, abp_pkg::TIMEOUT_RESET, 1'b0, 35);

    if (mismatch_count == 0 && packets_due.size() == 0) begin
      $display("abp_sender_with_queue_unit: match");
    end else begin
      $display("abp_sender_with_queue_unit: mismatch");
    end
    $finish;
  end

endmodule

### files.f
sv/abp_pkg.sv
sv/abp_if.sv
sv/abp_queue.sv
sv/abp_sender_with_queue_unit.sv
tb/testbench.sv
